// File: design/assert_macros.svh
// Assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset
`define ASC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("arc segment count check failed");

// Checked on every edge, reset included
`define ASC_ASSERT_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("arc segment count check failed");

`endif

// File: design/asc_pkg.sv
package asc_pkg;

  localparam int MAX_SEGMENTS      = 4096;
  localparam int CORDIC_ITERATIONS = 32;

  localparam int CNT_W   = 13;
  localparam int OUT_MAX = (1 << CNT_W) - 1;
  localparam int HI_SEG  = (MAX_SEGMENTS > OUT_MAX) ? OUT_MAX : MAX_SEGMENTS;
  localparam int IT_W    = $clog2(CORDIC_ITERATIONS);

  localparam int DIV_W  = 36;
  localparam int ROOT_W = 64;
  localparam int RREM_W = 36;
  localparam int CORD_W = 36;
  localparam int BASE_W = 4;
  localparam int BASE_STEPS = 11;

  localparam int DIV1_STEPS = 31;
  localparam int ROOT_STEPS = 32;
  localparam int DIV2_STEPS = DIV_W;
  localparam int ROOT_BASE  = DIV1_STEPS;
  localparam int COR_BASE   = ROOT_BASE + ROOT_STEPS;
  localparam int DIV2_BASE  = COR_BASE + CORDIC_ITERATIONS;
  localparam int LAST       = DIV2_BASE + DIV2_STEPS;

  localparam logic [DIV_W-1:0] QUARTER_PI = DIV_W'(64'hC90FDAA2);

  localparam logic [31:0] ATAN_SMALL [BASE_STEPS] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100634, 32'd268086748,
    32'd134174063, 32'd67103403, 32'd33553749, 32'd16777131, 32'd8388597,
    32'd4194303
  };

  typedef enum logic [1:0] {
    REG_TOL        = 2'd0,
    REG_MIN        = 2'd1,
    REG_SWEEP_EPS  = 2'd2,
    REG_RADIUS_EPS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              vld;
    logic              skip;
    logic              refine;
    logic [DIV_W-1:0]  ang;
    logic [BASE_W-1:0] base;
  } side_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] dvs;
    logic [DIV_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rad;
    logic [RREM_W-1:0] rem;
    logic [31:0]       root;
  } root_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
  } cord_t;

  // Rounded atan(2^-i) in Q0.32
  function automatic logic [CORD_W-1:0] atan_entry(input logic [IT_W-1:0] i);
    logic [CORD_W-1:0] r;
    int unsigned       k;
    k = i;
    if (k < BASE_STEPS) begin
      r = CORD_W'(ATAN_SMALL[k[3:0]]);
    end else if (k <= 32) begin
      r = CORD_W'(64'd1 << (32 - k));
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

// File: design/asc_div_cell.sv
module asc_div_cell (
  input  logic          clk,
  input  logic          en,
  input  asc_pkg::div_t d_in,
  output asc_pkg::div_t d_out
);

  logic [asc_pkg::DIV_W:0] sh;
  logic                    ge;
  asc_pkg::div_t           d_nxt;
  asc_pkg::div_t           d_r;

  // One restoring quotient bit
  always_comb begin
    sh          = {d_in.rem, d_in.num[asc_pkg::DIV_W-1]};
    ge          = sh >= {1'b0, d_in.dvs};
    d_nxt.dvs   = d_in.dvs;
    d_nxt.num   = {d_in.num[asc_pkg::DIV_W-2:0], 1'b0};
    d_nxt.quo   = {d_in.quo[asc_pkg::DIV_W-2:0], ge};
    d_nxt.rem   = ge ? asc_pkg::DIV_W'(sh - {1'b0, d_in.dvs})
                     : sh[asc_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// File: design/asc_root_cell.sv
module asc_root_cell (
  input  logic           clk,
  input  logic           en,
  input  asc_pkg::root_t r_in,
  output asc_pkg::root_t r_out
);

  logic [asc_pkg::RREM_W-1:0] rem_sh;
  logic [31:0]                root_sh;
  logic [asc_pkg::RREM_W-1:0] trial;
  asc_pkg::root_t             r_nxt;
  asc_pkg::root_t             r_r;

  // One digit of the square root
  always_comb begin
    rem_sh    = {r_in.rem[asc_pkg::RREM_W-3:0], r_in.rad[asc_pkg::ROOT_W-1 -: 2]};
    root_sh   = {r_in.root[30:0], 1'b0};
    trial     = asc_pkg::RREM_W'({root_sh, 1'b1});
    r_nxt.rad = {r_in.rad[asc_pkg::ROOT_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r_nxt.rem  = rem_sh - trial;
      r_nxt.root = root_sh | 32'd1;
    end else begin
      r_nxt.rem  = rem_sh;
      r_nxt.root = root_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
    end
  end

  assign r_out = r_r;

endmodule

// File: design/asc_cordic_cell.sv
module asc_cordic_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic [asc_pkg::IT_W-1:0] iter,
  input  asc_pkg::cord_t           c_in,
  output asc_pkg::cord_t           c_out
);

  logic signed [asc_pkg::CORD_W-1:0] dx;
  logic signed [asc_pkg::CORD_W-1:0] dy;
  logic signed [asc_pkg::CORD_W-1:0] at;
  asc_pkg::cord_t                    c_nxt;
  asc_pkg::cord_t                    c_r;

  // Vectoring rotation: drive y towards zero
  always_comb begin
    dx = c_in.y >>> iter;
    dy = c_in.x >>> iter;
    at = $signed(asc_pkg::atan_entry(iter));
    if (!c_in.y[asc_pkg::CORD_W-1]) begin
      c_nxt.x = c_in.x + dx;
      c_nxt.y = c_in.y - dy;
      c_nxt.z = c_in.z + at;
    end else begin
      c_nxt.x = c_in.x - dx;
      c_nxt.y = c_in.y + dy;
      c_nxt.z = c_in.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

// File: design/arc_segment_count_top.sv
// Arc segment counter. Takes one arc (radius, signed sweep) per cycle unless the output stalls, and
// returns the number of line segments needed to draw it, at most 45 degrees each and, with a chord
// tolerance set, with sagitta error within it. Fully pipelined as a row of one-step cells: a 31-cell
// divider for tol/(2r), two 32-cell square-root rows, a CORDIC_ITERATIONS-cell arctangent row and a
// 36-cell divider for the count, plus an entry and an output register; one arc per cycle sustained
// while the output is not stalled. A stalled output holds the whole row. Write the configuration
// registers only while no arc is in flight.
module arc_segment_count_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               in_radius,
  input  logic signed [31:0]        in_sweep_angle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [asc_pkg::CNT_W-1:0] out_segment_count,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_wdata
);

  localparam int NC = asc_pkg::CORDIC_ITERATIONS;

  logic [31:0]               tol_r;
  logic [asc_pkg::CNT_W-1:0] min_r;
  logic [15:0]               sweep_eps_r;
  logic [15:0]               radius_eps_r;

  logic adv;

  asc_pkg::side_t side_r   [0:asc_pkg::LAST];
  asc_pkg::side_t side_nxt [0:asc_pkg::LAST];

  asc_pkg::div_t  d1_io [0:asc_pkg::DIV1_STEPS];
  asc_pkg::div_t  d1_nxt;
  asc_pkg::root_t rs_io [0:asc_pkg::ROOT_STEPS];
  asc_pkg::root_t rc_io [0:asc_pkg::ROOT_STEPS];
  asc_pkg::cord_t cf_io [0:NC];
  asc_pkg::div_t  d2_io [0:asc_pkg::DIV2_STEPS];

  logic [30:0]               u;
  logic [asc_pkg::DIV_W-1:0] maxang;
  logic [31:0]               mag;

  logic                      out_valid_r;
  logic [asc_pkg::CNT_W-1:0] out_count_r;
  logic [asc_pkg::CNT_W-1:0] count_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r        <= '0;
      min_r        <= asc_pkg::CNT_W'(1);
      sweep_eps_r  <= 16'd1;
      radius_eps_r <= 16'd1;
    end else if (cfg_wr_en) begin
      case (asc_pkg::reg_idx_t'(cfg_index))
        asc_pkg::REG_TOL:        tol_r        <= cfg_wdata;
        asc_pkg::REG_MIN:        min_r        <= cfg_wdata[asc_pkg::CNT_W-1:0];
        asc_pkg::REG_SWEEP_EPS:  sweep_eps_r  <= cfg_wdata[15:0];
        asc_pkg::REG_RADIUS_EPS: radius_eps_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Entry stage: magnitude, skip test, base count, refinement decision and divider operands
  always_comb begin
    mag = in_sweep_angle[31] ? 32'(33'h1_0000_0000 - {1'b0, in_sweep_angle})
                             : in_sweep_angle;
    side_nxt[0].vld    = in_valid;
    side_nxt[0].skip   = mag < {16'd0, sweep_eps_r};
    side_nxt[0].ang    = {mag, 4'b0000};
    side_nxt[0].refine = (tol_r != 32'd0) && (in_radius > {16'd0, radius_eps_r})
                         && (tol_r < in_radius);
    side_nxt[0].base   = '0;
    for (int k = 0; k < asc_pkg::BASE_STEPS; k++) begin
      if ({mag, 4'b0000} > asc_pkg::DIV_W'(k) * asc_pkg::QUARTER_PI) begin
        side_nxt[0].base = side_nxt[0].base + asc_pkg::BASE_W'(1);
      end
    end
    d1_nxt.rem = {4'd0, tol_r};
    d1_nxt.num = '0;
    d1_nxt.dvs = {4'd0, in_radius};
    d1_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_io[0] <= d1_nxt;
    end
  end

  assign u = d1_io[asc_pkg::DIV1_STEPS].quo[30:0];

  // Sideband travels alongside the cells; drop refinement where it gives nothing
  for (genvar j = 1; j <= asc_pkg::LAST; j++) begin : g_side
    always_comb begin
      side_nxt[j] = side_r[j-1];
      if (j - 1 == asc_pkg::ROOT_BASE) begin
        side_nxt[j].refine = side_r[j-1].refine && (u != 31'd0);
      end
      if (j - 1 == asc_pkg::DIV2_BASE) begin
        side_nxt[j].refine = side_r[j-1].refine && (maxang != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= asc_pkg::LAST; j++) begin
        side_r[j].vld <= 1'b0;
      end
    end else if (adv) begin
      for (int j = 0; j <= asc_pkg::LAST; j++) begin
        side_r[j] <= side_nxt[j];
      end
    end
  end

  for (genvar k = 0; k < asc_pkg::DIV1_STEPS; k++) begin : g_div1
    asc_div_cell u_cell (.clk(clk), .en(adv), .d_in(d1_io[k]), .d_out(d1_io[k+1]));
  end

  // sqrt(u) and sqrt(1-u) in Q0.32
  assign rs_io[0].rad  = {1'b0, u, 32'd0};
  assign rs_io[0].rem  = '0;
  assign rs_io[0].root = '0;
  assign rc_io[0].rad  = {32'(33'h1_0000_0000 - {2'b00, u}), 32'd0};
  assign rc_io[0].rem  = '0;
  assign rc_io[0].root = '0;

  for (genvar k = 0; k < asc_pkg::ROOT_STEPS; k++) begin : g_root
    asc_root_cell u_s (.clk(clk), .en(adv), .r_in(rs_io[k]), .r_out(rs_io[k+1]));
    asc_root_cell u_c (.clk(clk), .en(adv), .r_in(rc_io[k]), .r_out(rc_io[k+1]));
  end

  assign cf_io[0].x = $signed({4'd0, rc_io[asc_pkg::ROOT_STEPS].root});
  assign cf_io[0].y = $signed({4'd0, rs_io[asc_pkg::ROOT_STEPS].root});
  assign cf_io[0].z = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cordic
    asc_cordic_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .iter (asc_pkg::IT_W'(k)),
      .c_in (cf_io[k]),
      .c_out(cf_io[k+1])
    );
  end

  // Clamp the angle at zero and scale by four
  assign maxang = cf_io[NC].z[asc_pkg::CORD_W-1] ? '0
                : {cf_io[NC].z[asc_pkg::DIV_W-3:0], 2'b00};

  assign d2_io[0].rem = '0;
  assign d2_io[0].num = side_r[asc_pkg::DIV2_BASE].ang;
  assign d2_io[0].dvs = maxang;
  assign d2_io[0].quo = '0;

  for (genvar k = 0; k < asc_pkg::DIV2_STEPS; k++) begin : g_div2
    asc_div_cell u_cell (.clk(clk), .en(adv), .d_in(d2_io[k]), .d_out(d2_io[k+1]));
  end

  // Final selection and clamping
  always_comb begin
    logic [asc_pkg::DIV_W:0]   n2;
    logic [asc_pkg::DIV_W:0]   n;
    logic [asc_pkg::CNT_W-1:0] lo;
    asc_pkg::side_t            sd;
    sd = side_r[asc_pkg::LAST];
    n2 = {1'b0, d2_io[asc_pkg::DIV2_STEPS].quo}
         + (asc_pkg::DIV_W+1)'(d2_io[asc_pkg::DIV2_STEPS].rem != '0);
    if (min_r == '0) begin
      lo = asc_pkg::CNT_W'(1);
    end else if (min_r > asc_pkg::CNT_W'(asc_pkg::HI_SEG)) begin
      lo = asc_pkg::CNT_W'(asc_pkg::HI_SEG);
    end else begin
      lo = min_r;
    end
    n = (asc_pkg::DIV_W+1)'(sd.base);
    if (sd.refine && n2 > n) begin
      n = n2;
    end
    if (n < (asc_pkg::DIV_W+1)'(lo)) begin
      n = (asc_pkg::DIV_W+1)'(lo);
    end
    if (n > (asc_pkg::DIV_W+1)'(asc_pkg::HI_SEG)) begin
      n = (asc_pkg::DIV_W+1)'(asc_pkg::HI_SEG);
    end
    count_nxt = sd.skip ? lo : n[asc_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= side_r[asc_pkg::LAST].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_count_r <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_count = out_count_r;

endmodule

// File: design/asc_checker.sv
`include "assert_macros.svh"

module asc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [asc_pkg::CNT_W-1:0] out_segment_count
);

  // Hold a stalled result
  `ASC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_segment_count))

  // Count stays inside the clamp range
  `ASC_ASSERT(a_count_range, out_valid |-> out_segment_count >= asc_pkg::CNT_W'(1) && out_segment_count <= asc_pkg::CNT_W'(asc_pkg::HI_SEG))

  // Take a request whenever the output slot can move
  `ASC_ASSERT(a_ready, in_ready == (!out_valid || out_ready))

  // No result straight out of reset
  `ASC_ASSERT_ALL(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

bind arc_segment_count_top asc_checker u_asc_checker (.*);
